// ===== hw/rtl/mhnt_pkg.sv =====
// ============================================================================
// MIDI hanging note tracker package
// Shared types and codes for the controller, the datapath and the top level.
// ============================================================================
package mhnt_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_TAKEN   = 2'd0;
    localparam logic [1:0] KIND_IGNORED = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Item commands.
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // MIDI message types (status high nibble).
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_SYSTEM   = 4'hF;

    // Byte counts.
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_FULL = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EVENT,
        ST_SCAN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ev_load;    // latch an event beat and read its counter
        logic ev_commit;  // write the updated counter and present the result
        logic clr_write;  // clear one counter of the reset sweep
        logic scan_start; // restart the drain scan at the first counter
        logic scan_run;   // advance the drain scan by one counter
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // the sweep is at the last counter
        logic chk_hit;    // the checked counter is nonzero
        logic chk_end;    // the checked counter is the last one
    } dp_stat_t;

endpackage

// ===== hw/rtl/midi_hanging_note_tracker_top.sv =====
// ============================================================================
// MIDI hanging note tracker
// Counts outstanding notes per channel and note, and drains them on request.
// ============================================================================
// Usage:
// A beat is accepted at a rising clock edge where start is high and busy is
// low. With cmd low the beat is a MIDI event of byte_count bytes; with cmd
// high it asks for one outstanding note to be closed.
// Every beat produces exactly one result, shown on kind, channel, note and
// outstanding for a single cycle while done is high. The receiver cannot
// stall, so results must be captured in that cycle.
// An event first reads its counter into the registered read port of the
// counter memory, then writes the updated counter and registers the result.
// The next beat can be accepted in the cycle the result is shown.
// A drain beat scans the counter memory one counter per cycle, channel first
// and note ascending, and stops at the first nonzero counter, or after the
// last of the CHANNELS * 2**ceil(log2(NOTES)) counters when every counter
// is zero.
// After reset the block sweeps the counter memory to zero, one counter per
// cycle, and holds busy high until it is done.
// ============================================================================
module midi_hanging_note_tracker_top
#(
    parameter int COUNT_BITS = 8,
    parameter int CHANNELS   = 16,
    parameter int NOTES      = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       cmd,
    input  logic [1:0] byte_count,
    input  logic [7:0] status_byte,
    input  logic [6:0] note_byte,
    input  logic [6:0] velocity_byte,
    output logic       done,
    output logic [1:0] kind,
    output logic [3:0] channel,
    output logic [6:0] note,
    output logic [7:0] outstanding
);

    // Commands and status between the sequencer and the datapath.
    mhnt_pkg::dp_cmd_t  ctl;
    mhnt_pkg::dp_stat_t stat;

    // The controller decides what happens in each cycle.
    mhnt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // The datapath holds the counters and forms every result.
    mhnt_dp
    #(
        .COUNT_BITS (COUNT_BITS),
        .CHANNELS   (CHANNELS),
        .NOTES      (NOTES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .byte_count    (byte_count),
        .status_byte   (status_byte),
        .note_byte     (note_byte),
        .velocity_byte (velocity_byte),
        .done          (done),
        .kind          (kind),
        .channel       (channel),
        .note          (note),
        .outstanding   (outstanding)
    );

endmodule

// ===== hw/rtl/mhnt_ctrl.sv =====
// ============================================================================
// MIDI hanging note tracker controller
// Sequences the reset sweep, event read-modify-write and drain scans.
// ============================================================================
module mhnt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    input  mhnt_pkg::dp_stat_t stat,
    output mhnt_pkg::dp_cmd_t  ctl,
    output logic               busy
);

    mhnt_pkg::ctrl_state_t state_reg;
    mhnt_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhnt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        case (state_reg)
            mhnt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (cmd == mhnt_pkg::CMD_DRAIN)
                    begin
                        ctl.scan_start = 1'b1;
                        state_next     = mhnt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        ctl.ev_load = 1'b1;
                        state_next  = mhnt_pkg::ST_EVENT;
                    end
                end
            end
            mhnt_pkg::ST_CLEAR:
            begin
                ctl.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = mhnt_pkg::ST_IDLE;
                end
            end
            mhnt_pkg::ST_EVENT:
            begin
                ctl.ev_commit = 1'b1;
                state_next    = mhnt_pkg::ST_IDLE;
            end
            mhnt_pkg::ST_SCAN:
            begin
                ctl.scan_run = 1'b1;
                if (stat.chk_hit || stat.chk_end)
                begin
                    state_next = mhnt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhnt_pkg::ST_IDLE;
            end
        endcase
    end

    // An event always finishes its read-modify-write in the event state and returns straight to idle.
    a_event_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhnt_pkg::ST_EVENT) |=> (state_reg == mhnt_pkg::ST_IDLE))
        else $error("event state did not return to idle");

endmodule

// ===== hw/rtl/mhnt_dp.sv =====
// ============================================================================
// MIDI hanging note tracker datapath
// Counter memory, event decode and update, drain scan and result registers.
// ============================================================================
module mhnt_dp
#(
    parameter int COUNT_BITS = 8,
    parameter int CHANNELS   = 16,
    parameter int NOTES      = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mhnt_pkg::dp_cmd_t  ctl,
    output mhnt_pkg::dp_stat_t stat,
    input  logic [1:0]         byte_count,
    input  logic [7:0]         status_byte,
    input  logic [6:0]         note_byte,
    input  logic [6:0]         velocity_byte,
    output logic               done,
    output logic [1:0]         kind,
    output logic [3:0]         channel,
    output logic [6:0]         note,
    output logic [7:0]         outstanding
);

    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NOTE_BITS = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int DEPTH     = CHANNELS << NOTE_BITS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Counter memory and its registered read port.
    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]  mem_ra;
    logic [ADDR_BITS-1:0]  mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic                  mem_we;

    // Event decode.
    logic [6:0]           b1;
    logic [6:0]           b2;
    logic [3:0]           mtype;
    logic [3:0]           mch;
    logic                 oor;
    logic                 is_on;
    logic                 is_off;
    logic [ADDR_BITS-1:0] ev_addr;

    // Latched event.
    logic [ADDR_BITS-1:0] ev_addr_reg;
    logic [3:0]           ev_ch_reg;
    logic [6:0]           ev_note_reg;
    logic                 ev_ignored_reg;
    logic                 ev_system_reg;
    logic                 ev_oor_reg;
    logic                 ev_on_reg;
    logic                 ev_off_reg;
    logic                 ev_access;
    logic [COUNT_BITS-1:0] upd;

    // Sweep and scan.
    logic [ADDR_BITS-1:0] scan_addr_reg;
    logic [ADDR_BITS-1:0] scan_addr_next;
    logic [ADDR_BITS-1:0] chk_addr_reg;
    logic                 chk_valid_reg;
    logic                 chk_valid_next;
    logic [COUNT_BITS-1:0] dec;

    // Results.
    logic       done_reg;
    logic       done_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [3:0] channel_reg;
    logic [3:0] channel_next;
    logic [6:0] note_reg;
    logic [6:0] note_next;
    logic [7:0] outstanding_reg;
    logic [7:0] outstanding_next;

    always_comb
    begin
        mtype  = status_byte[7:4];
        mch    = status_byte[3:0];
        b1     = (byte_count >= mhnt_pkg::LEN_TWO) ? note_byte : 7'd0;
        b2     = (byte_count == mhnt_pkg::LEN_FULL) ? velocity_byte : 7'd0;
        oor    = ({1'b0, mch} >= 5'(CHANNELS)) || ({1'b0, b1} >= 8'(NOTES));
        is_on  = (mtype == mhnt_pkg::MSG_NOTE_ON) && (b2 != 7'd0);
        is_off = (mtype == mhnt_pkg::MSG_NOTE_OFF)
                 || ((byte_count == mhnt_pkg::LEN_FULL)
                     && (mtype == mhnt_pkg::MSG_NOTE_ON) && (b2 == 7'd0));
        ev_addr = oor ? '0 : ADDR_BITS'({mch[CH_BITS-1:0], b1[NOTE_BITS-1:0]});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ev_load)
        begin
            ev_addr_reg    <= ev_addr;
            ev_ch_reg      <= mch;
            ev_note_reg    <= b1;
            ev_ignored_reg <= (byte_count == mhnt_pkg::LEN_NONE);
            ev_system_reg  <= (mtype == mhnt_pkg::MSG_SYSTEM);
            ev_oor_reg     <= oor;
            ev_on_reg      <= is_on;
            ev_off_reg     <= is_off;
        end
    end

    always_comb
    begin
        ev_access = !ev_ignored_reg && !ev_system_reg && !ev_oor_reg;
        dec       = rd_data_reg - 1'b1;
        if (ev_on_reg)
        begin
            upd = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
        end
        else if (ev_off_reg && (rd_data_reg != '0))
        begin
            upd = dec;
        end
        else
        begin
            upd = rd_data_reg;
        end
    end

    // Status of the sweep and of the counter under check.
    always_comb
    begin
        stat.clr_last = (scan_addr_reg == LAST_ADDR);
        stat.chk_hit  = chk_valid_reg && (rd_data_reg != '0);
        stat.chk_end  = chk_valid_reg && (chk_addr_reg == LAST_ADDR);
    end

    // Memory port selection.
    always_comb
    begin
        mem_ra = ctl.ev_load ? ev_addr : scan_addr_reg;
        mem_we = 1'b0;
        mem_wa = chk_addr_reg;
        mem_wd = dec;
        if (ctl.ev_commit)
        begin
            mem_we = ev_access;
            mem_wa = ev_addr_reg;
            mem_wd = upd;
        end
        else if (ctl.clr_write)
        begin
            mem_we = 1'b1;
            mem_wa = scan_addr_reg;
            mem_wd = '0;
        end
        else if (ctl.scan_run && stat.chk_hit)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= count_mem[mem_ra];
    end

    // Sweep and scan counters.
    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        chk_valid_next = chk_valid_reg;
        if (ctl.scan_start)
        begin
            scan_addr_next = '0;
            chk_valid_next = 1'b0;
        end
        else if (ctl.clr_write || ctl.scan_run)
        begin
            scan_addr_next = (scan_addr_reg == LAST_ADDR) ? '0 : scan_addr_reg + 1'b1;
            chk_valid_next = ctl.scan_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            scan_addr_reg <= scan_addr_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_run)
        begin
            chk_addr_reg <= scan_addr_reg;
        end
    end

    // Result formation.
    always_comb
    begin
        done_next        = 1'b0;
        kind_next        = kind_reg;
        channel_next     = channel_reg;
        note_next        = note_reg;
        outstanding_next = outstanding_reg;
        if (ctl.ev_commit)
        begin
            done_next = 1'b1;
            if (ev_ignored_reg)
            begin
                kind_next        = mhnt_pkg::KIND_IGNORED;
                channel_next     = 4'd0;
                note_next        = 7'd0;
                outstanding_next = 8'd0;
            end
            else if (ev_system_reg)
            begin
                kind_next        = mhnt_pkg::KIND_TAKEN;
                channel_next     = 4'd0;
                note_next        = 7'd0;
                outstanding_next = 8'd0;
            end
            else
            begin
                kind_next        = mhnt_pkg::KIND_TAKEN;
                channel_next     = ev_ch_reg;
                note_next        = ev_note_reg;
                outstanding_next = ev_oor_reg ? 8'd0 : 8'(upd);
            end
        end
        else if (ctl.scan_run && stat.chk_hit)
        begin
            done_next        = 1'b1;
            kind_next        = mhnt_pkg::KIND_CLOSE;
            channel_next     = 4'(chk_addr_reg >> NOTE_BITS);
            note_next        = 7'(chk_addr_reg[NOTE_BITS-1:0]);
            outstanding_next = 8'(dec);
        end
        else if (ctl.scan_run && stat.chk_end)
        begin
            done_next        = 1'b1;
            kind_next        = mhnt_pkg::KIND_DONE;
            channel_next     = 4'd0;
            note_next        = 7'd0;
            outstanding_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        channel_reg     <= channel_next;
        note_reg        <= note_next;
        outstanding_reg <= outstanding_next;
    end

    assign done        = done_reg;
    assign kind        = kind_reg;
    assign channel     = channel_reg;
    assign note        = note_reg;
    assign outstanding = outstanding_reg;

    // A commit always works on the counter read in the cycle before.
    a_commit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ev_commit |-> $past(ctl.ev_load))
        else $error("event commit without a preceding load");

    // Two results never come in adjacent cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // The reset sweep produces no results.
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_write |=> !done_reg)
        else $error("result strobe during the clear sweep");

endmodule
